// ===== src/hclru_pkg.sv =====
package hclru_pkg;

    localparam int SLOT_W        = 8;
    localparam int SLOT_OUT_W    = 6;
    localparam int ANIM_W        = 11;
    localparam int STAMP_W       = 32;
    localparam int NUM_SLOTS_DEF = 40;
    localparam int MAX_ANIMS_DEF = 2048;

    localparam logic [SLOT_W-1:0]         UNMAPPED    = 8'hff;
    localparam logic signed [STAMP_W-1:0] STAMP_RESET = -32'sd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_RANGE,
        ST_SCAN,
        ST_UNMAP,
        ST_MAP
    } t_state;

    typedef struct packed {
        logic                      live;
        logic                      has;
        logic signed [STAMP_W-1:0] stamp;
        logic [SLOT_W-1:0]         idx;
        logic [ANIM_W-1:0]         owner;
    } t_token;

    typedef struct packed {
        logic                      stamp_en;
        logic                      owner_en;
        logic [SLOT_W-1:0]         idx;
        logic signed [STAMP_W-1:0] stamp;
        logic [ANIM_W-1:0]         owner;
    } t_cell_wr;

endpackage

// ===== src/header_cache_lru_policy_top.sv =====
// Channel   Direction  Ports                                   Transfer
// request   in         i_anim_number, i_now_tick               start && !busy
// result    out        o_slot_index, o_load_needed,            o_valid
//                      o_evicted_valid, o_evicted_anim
//
// A hit shows its result in the cycle after the request transfer, and the
// block then returns to idle, ready for the next request.
// A miss shows its result in the map state, after the lookup, the scan in which
// the stamp minimum token walks the row of slot cells, one cell per cycle,
// and the unmap state.
// After reset a clearing pass writes every map entry with busy high.
// The result is shown for one cycle with o_valid; the receiver cannot stall.
module header_cache_lru_policy_top #(
    parameter int NUM_SLOTS = hclru_pkg::NUM_SLOTS_DEF,
    parameter int MAX_ANIMS = hclru_pkg::MAX_ANIMS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [hclru_pkg::ANIM_W-1:0]           i_anim_number,
    input  logic signed [hclru_pkg::STAMP_W-1:0]   i_now_tick,
    output logic                                   o_valid,
    output logic [hclru_pkg::SLOT_OUT_W-1:0]       o_slot_index,
    output logic                                   o_load_needed,
    output logic                                   o_evicted_valid,
    output logic [hclru_pkg::ANIM_W-1:0]           o_evicted_anim
);

    localparam int AW = $clog2(MAX_ANIMS);
    localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ANIMS - 1);
    localparam logic [hclru_pkg::SLOT_W-1:0] SLOT_LAST = hclru_pkg::SLOT_W'(NUM_SLOTS - 1);

    hclru_pkg::t_state                      r_state;
    hclru_pkg::t_state                      n_state;
    logic [AW-1:0]                          r_clr;
    logic [hclru_pkg::ANIM_W-1:0]           r_anim;
    logic signed [hclru_pkg::STAMP_W-1:0]   r_tick;
    logic [hclru_pkg::SLOT_W-1:0]           r_next;
    logic [hclru_pkg::SLOT_W-1:0]           r_vic;
    logic [hclru_pkg::ANIM_W-1:0]           r_old;

    logic                                   map_we;
    logic [AW-1:0]                          map_addr;
    logic [hclru_pkg::SLOT_W-1:0]           map_wdata;
    logic [hclru_pkg::SLOT_W-1:0]           map_rdata;

    logic                                   in_range;
    logic                                   hit;
    logic                                   old_evict;
    logic [hclru_pkg::SLOT_W-1:0]           slot8;
    hclru_pkg::t_cell_wr                    cell_wr;
    hclru_pkg::t_token                      tok [NUM_SLOTS+1];

    assign in_range  = (32'(i_anim_number) < MAX_ANIMS);
    assign hit       = (32'(map_rdata) < NUM_SLOTS);
    assign old_evict = (r_old != '0);

    hclru_map #(
        .MAX_ANIMS (MAX_ANIMS),
        .AW        (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_addr  (map_addr),
        .i_wdata (map_wdata),
        .o_rdata (map_rdata)
    );

    always_comb begin
        tok[0]       = '0;
        tok[0].live  = (r_state == hclru_pkg::ST_LOOKUP) && !hit;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        hclru_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_next_slot (r_next),
            .i_wr        (cell_wr),
            .i_tok       (tok[g]),
            .o_tok       (tok[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hclru_pkg::ST_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = hclru_pkg::ST_IDLE;
                end
            end
            hclru_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = in_range ? hclru_pkg::ST_LOOKUP : hclru_pkg::ST_RANGE;
                end
            end
            hclru_pkg::ST_LOOKUP: begin
                n_state = hit ? hclru_pkg::ST_IDLE : hclru_pkg::ST_SCAN;
            end
            hclru_pkg::ST_RANGE: n_state = hclru_pkg::ST_IDLE;
            hclru_pkg::ST_SCAN: begin
                if (tok[NUM_SLOTS].live) begin
                    n_state = hclru_pkg::ST_UNMAP;
                end
            end
            hclru_pkg::ST_UNMAP: n_state = hclru_pkg::ST_MAP;
            hclru_pkg::ST_MAP:   n_state = hclru_pkg::ST_IDLE;
            default:             n_state = hclru_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        busy            = 1'b1;
        o_valid         = 1'b0;
        slot8           = '0;
        o_load_needed   = 1'b0;
        o_evicted_valid = 1'b0;
        o_evicted_anim  = '0;
        map_we          = 1'b0;
        map_addr        = AW'(r_anim);
        map_wdata       = hclru_pkg::UNMAPPED;
        cell_wr         = '0;
        cell_wr.stamp   = r_tick;
        cell_wr.owner   = r_anim;
        unique case (r_state)
            hclru_pkg::ST_CLEAR: begin
                map_we   = 1'b1;
                map_addr = r_clr;
            end
            hclru_pkg::ST_IDLE: begin
                busy     = 1'b0;
                map_addr = AW'(i_anim_number);
            end
            hclru_pkg::ST_LOOKUP: begin
                if (hit) begin
                    o_valid          = 1'b1;
                    slot8            = map_rdata;
                    cell_wr.stamp_en = 1'b1;
                    cell_wr.idx      = map_rdata;
                end
            end
            hclru_pkg::ST_RANGE: begin
                o_valid = 1'b1;
            end
            hclru_pkg::ST_SCAN: begin
            end
            hclru_pkg::ST_UNMAP: begin
                map_we   = old_evict && (32'(r_old) < MAX_ANIMS);
                map_addr = AW'(r_old);
            end
            hclru_pkg::ST_MAP: begin
                map_we           = 1'b1;
                map_wdata        = r_vic;
                cell_wr.stamp_en = 1'b1;
                cell_wr.owner_en = 1'b1;
                cell_wr.idx      = r_vic;
                o_valid          = 1'b1;
                slot8            = r_vic;
                o_load_needed    = 1'b1;
                o_evicted_valid  = old_evict;
                o_evicted_anim   = r_old;
            end
            default: begin
            end
        endcase
    end

    assign o_slot_index = slot8[hclru_pkg::SLOT_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hclru_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_next  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == hclru_pkg::ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == hclru_pkg::ST_LOOKUP && hit) begin
                r_next <= (map_rdata == SLOT_LAST) ? '0 : map_rdata + 8'd1;
            end
            if (r_state == hclru_pkg::ST_MAP) begin
                r_next <= (r_vic == SLOT_LAST) ? '0 : r_vic + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hclru_pkg::ST_IDLE && start) begin
            r_anim <= i_anim_number;
            r_tick <= i_now_tick;
        end
        if (tok[NUM_SLOTS].live) begin
            r_vic <= tok[NUM_SLOTS].idx;
            r_old <= tok[NUM_SLOTS].owner;
        end
    end

`ifndef SYNTHESIS
    // The search token only reaches the end of the row during a scan.
    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[NUM_SLOTS].live |-> (r_state == hclru_pkg::ST_SCAN))
        else $error("search token left the row outside a scan");

    // A miss in the lookup must launch a scan.
    a_miss_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hclru_pkg::ST_LOOKUP && !hit) |=> (r_state == hclru_pkg::ST_SCAN))
        else $error("miss did not start a scan");

    // The victim written back is a real slot.
    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hclru_pkg::ST_MAP) |-> (32'(r_vic) < NUM_SLOTS))
        else $error("victim slot out of range");

    // The next-slot pointer always names a real slot.
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_next) < NUM_SLOTS)
        else $error("next-slot pointer out of range");

    // A result transfer is only offered while a request is in progress.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (busy && $past(busy || start)))
        else $error("result without a request");
`endif

endmodule

// ===== src/hclru_cell.sv =====
module hclru_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [hclru_pkg::SLOT_W-1:0]       i_next_slot,
    input  hclru_pkg::t_cell_wr                i_wr,
    input  hclru_pkg::t_token                  i_tok,
    output hclru_pkg::t_token                  o_tok
);

    localparam logic [hclru_pkg::SLOT_W-1:0] MY_IDX = hclru_pkg::SLOT_W'(CELL_IDX);

    logic signed [hclru_pkg::STAMP_W-1:0] r_stamp;
    logic [hclru_pkg::ANIM_W-1:0]         r_owner;
    hclru_pkg::t_token                    r_tok;
    hclru_pkg::t_token                    n_tok;
    logic                                 take;
    logic                                 sel;

    assign sel = (i_wr.idx == MY_IDX);

    // A slot wins on a strictly smaller stamp; on a tie only the next-slot
    // pointer may displace the current candidate.
    assign take = !i_tok.has || (r_stamp < i_tok.stamp) ||
                  ((r_stamp == i_tok.stamp) && (i_next_slot == MY_IDX));

    always_comb begin
        n_tok      = i_tok;
        n_tok.has  = 1'b1;
        if (take) begin
            n_tok.stamp = r_stamp;
            n_tok.idx   = MY_IDX;
            n_tok.owner = r_owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= hclru_pkg::STAMP_RESET;
            r_owner <= '0;
            r_tok   <= '0;
        end else begin
            if (i_wr.stamp_en && sel) begin
                r_stamp <= i_wr.stamp;
            end
            if (i_wr.owner_en && sel) begin
                r_owner <= i_wr.owner;
            end
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== src/hclru_map.sv =====
module hclru_map #(
    parameter int MAX_ANIMS = hclru_pkg::MAX_ANIMS_DEF,
    parameter int AW        = $clog2(MAX_ANIMS)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_addr,
    input  logic [hclru_pkg::SLOT_W-1:0]  i_wdata,
    output logic [hclru_pkg::SLOT_W-1:0]  o_rdata
);

    logic [hclru_pkg::SLOT_W-1:0] mem [MAX_ANIMS];
    logic [hclru_pkg::SLOT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/header_cache_lru_policy_top_tb.sv =====
module header_cache_lru_policy_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = hclru_pkg::NUM_SLOTS_DEF;
    localparam int MAX_ANIMS = hclru_pkg::MAX_ANIMS_DEF;
    localparam logic signed [hclru_pkg::STAMP_W-1:0] TICK_MIN = 32'sh8000_0000;
    localparam logic signed [hclru_pkg::STAMP_W-1:0] TICK_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [hclru_pkg::SLOT_OUT_W-1:0] slot;
        logic                             load;
        logic                             evicted;
        logic [hclru_pkg::ANIM_W-1:0]     evicted_anim;
    } t_lookup_result;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n;
    logic                                  start;
    logic                                  busy;
    logic [hclru_pkg::ANIM_W-1:0]          i_anim_number;
    logic signed [hclru_pkg::STAMP_W-1:0]  i_now_tick;
    logic                                  o_valid;
    logic [hclru_pkg::SLOT_OUT_W-1:0]      o_slot_index;
    logic                                  o_load_needed;
    logic                                  o_evicted_valid;
    logic [hclru_pkg::ANIM_W-1:0]          o_evicted_anim;

    logic [hclru_pkg::SLOT_W-1:0]          map_slot [MAX_ANIMS];
    logic [hclru_pkg::ANIM_W-1:0]          owner_of [NUM_SLOTS];
    logic signed [hclru_pkg::STAMP_W-1:0]  stamp_of [NUM_SLOTS];
    int                                    next_victim;
    t_lookup_result                        pending_lookups [$];
    int                                    mismatches = 0;

    header_cache_lru_policy_top #(
        .NUM_SLOTS(NUM_SLOTS),
        .MAX_ANIMS(MAX_ANIMS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_anim_number(i_anim_number),
        .i_now_tick(i_now_tick),
        .o_valid(o_valid),
        .o_slot_index(o_slot_index),
        .o_load_needed(o_load_needed),
        .o_evicted_valid(o_evicted_valid),
        .o_evicted_anim(o_evicted_anim)
    );

    always #1 i_clk = ~i_clk;

    function automatic void predict_lookup(
            input logic [hclru_pkg::ANIM_W-1:0] anim,
            input logic signed [hclru_pkg::STAMP_W-1:0] tick);
        t_lookup_result               res;
        logic [hclru_pkg::SLOT_W-1:0] mapped;
        int                           victim;
        logic [hclru_pkg::ANIM_W-1:0] old;
        res = '0;
        mapped = map_slot[anim];
        if (mapped != hclru_pkg::UNMAPPED && mapped < NUM_SLOTS) begin
            stamp_of[mapped] = tick;
            next_victim = (mapped + 1) % NUM_SLOTS;
            res.slot = mapped[hclru_pkg::SLOT_OUT_W-1:0];
        end else begin
            victim = next_victim;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (stamp_of[i] < stamp_of[victim]) begin
                    victim = i;
                end
            end
            old = owner_of[victim];
            if (old != '0) begin
                map_slot[old] = hclru_pkg::UNMAPPED;
                res.evicted = 1'b1;
            end
            map_slot[anim] = hclru_pkg::SLOT_W'(victim);
            owner_of[victim] = anim;
            stamp_of[victim] = tick;
            next_victim = (victim + 1) % NUM_SLOTS;
            res.slot = hclru_pkg::SLOT_OUT_W'(victim);
            res.load = 1'b1;
            res.evicted_anim = old;
        end
        pending_lookups.push_back(res);
    endfunction

    task automatic send_request(input logic [hclru_pkg::ANIM_W-1:0] anim,
                                input logic signed [hclru_pkg::STAMP_W-1:0] tick);
        start <= 1'b1;
        i_anim_number <= anim;
        i_now_tick <= tick;
        do @(posedge i_clk); while (busy);
        predict_lookup(anim, tick);
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_lookup_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_lookups.size() == 0) begin
                $error("result with no request outstanding: slot %0d", o_slot_index);
                mismatches++;
            end else begin
                exp_res = pending_lookups.pop_front();
                if (o_slot_index !== exp_res.slot) begin
                    $error("slot_index expected %0d actual %0d", exp_res.slot, o_slot_index);
                    mismatches++;
                end
                if (o_load_needed !== exp_res.load) begin
                    $error("load_needed expected %0b actual %0b",
                           exp_res.load, o_load_needed);
                    mismatches++;
                end
                if (o_evicted_valid !== exp_res.evicted) begin
                    $error("evicted_valid expected %0b actual %0b",
                           exp_res.evicted, o_evicted_valid);
                    mismatches++;
                end
                if (o_evicted_anim !== exp_res.evicted_anim) begin
                    $error("evicted_anim expected %0d actual %0d",
                           exp_res.evicted_anim, o_evicted_anim);
                    mismatches++;
                end
            end
        end
    end

    // Extreme ticks; the second miss reclaims the slot held by animation zero,
    // whose map entry survives, so the following request for it hits.
    task automatic test_tick_extremes();
        send_request(11'd0, TICK_MIN);
        send_request(11'd2047, TICK_MAX);
        send_request(11'd0, 32'sd0);
        send_request(11'd2047, -32'sd1);
        send_request(11'h555, 32'sh5555_5555);
        send_request(11'h2aa, 32'shaaaa_aaaa);
    endtask

    // Untouched slots all carry the reset stamp, so the scan must keep the
    // next-slot pointer on ties.
    task automatic test_tie_breaks();
        send_request(11'd1, hclru_pkg::STAMP_RESET);
        send_request(11'd2, hclru_pkg::STAMP_RESET);
        idle_for(2);
        send_request(11'd3, hclru_pkg::STAMP_RESET);
        send_request(11'd4, hclru_pkg::STAMP_RESET);
    endtask

    task automatic test_hits();
        send_request(11'd1, 32'sd100);
        send_request(11'd3, 32'sd100);
        send_request(11'd2, hclru_pkg::STAMP_RESET);
        send_request(11'd9, 32'sd101);
        send_request(11'd9, 32'sd102);
    endtask

    task automatic test_anim_zero();
        send_request(11'd0, TICK_MIN);
        send_request(11'd0, TICK_MAX);
        send_request(11'd0, TICK_MIN);
    endtask

    task automatic test_random(input int count, input bit with_gaps);
        static int tick_now = 0;
        static int pool_base = 0;
        logic [hclru_pkg::ANIM_W-1:0]         anim;
        logic signed [hclru_pkg::STAMP_W-1:0] tick;
        logic [hclru_pkg::ANIM_W-1:0]         recent [$];
        int                                   pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) == 0) begin
                pool_base = $urandom_range(0, MAX_ANIMS - 48);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                anim = hclru_pkg::ANIM_W'(pool_base + $urandom_range(0, 47));
            end else if (pick < 62) begin
                anim = '0;
            end else if (pick < 80 && recent.size() != 0) begin
                anim = recent[$urandom_range(0, recent.size() - 1)];
            end else begin
                anim = hclru_pkg::ANIM_W'($urandom);
            end
            tick_now += $urandom_range(0, 3);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                tick = $urandom;
            end else if (pick == 1) begin
                case ($urandom_range(0, 2))
                    0: tick = TICK_MIN;
                    1: tick = TICK_MAX;
                    default: tick = hclru_pkg::STAMP_RESET;
                endcase
            end else begin
                tick = tick_now;
            end
            send_request(anim, tick);
            recent.push_back(anim);
            if (recent.size() > 8) begin
                void'(recent.pop_front());
            end
            if (with_gaps && $urandom_range(0, 3) == 0) begin
                idle_for($urandom_range(1, 4));
            end
        end
    endtask

    initial begin
        for (int a = 0; a < MAX_ANIMS; a++) begin
            map_slot[a] = hclru_pkg::UNMAPPED;
        end
        for (int s = 0; s < NUM_SLOTS; s++) begin
            owner_of[s] = '0;
            stamp_of[s] = hclru_pkg::STAMP_RESET;
        end
        next_victim = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_anim_number <= '0;
        i_now_tick <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_tick_extremes();
        test_tie_breaks();
        test_hits();
        test_anim_zero();
        test_random(700, 1'b1);
        wait_drained();
        test_random(750, 1'b1);
        test_random(280, 1'b0);

        wait_drained();
        repeat (NUM_SLOTS + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hclru_pkg.sv
src/hclru_cell.sv
src/hclru_map.sv
src/header_cache_lru_policy_top.sv
test/header_cache_lru_policy_top_tb.sv
